/* rtl/rgbpk_pkg.sv */
// rgbpk_pkg: shared types, constants and the color placement function
// for the rgb888 direct color pixel packer; no dependencies
package rgbpk_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int WORD_BITS  = 32;
    localparam int OFFSET_W   = 28;
    localparam int COORD_W    = 12;
    localparam int BPP_W      = 3;
    localparam int PITCH_W    = 16;
    localparam int CUT_W      = 4;
    localparam int POS_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_BPP    = 4;

    // screen limits, 16-bit values
    localparam logic [15:0] MAX_WIDTH  = 16'd4096;
    localparam logic [15:0] MAX_HEIGHT = 16'd4096;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RED_CUT         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RED_LSB         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_CUT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LSB       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_CUT        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LSB        = 3'd7;

    typedef struct packed {
        logic [BPP_W-1:0]   bytes_per_pixel;
        logic [PITCH_W-1:0] line_pitch;
        logic [CUT_W-1:0]   red_cut;
        logic [POS_W-1:0]   red_lsb;
        logic [CUT_W-1:0]   green_cut;
        logic [POS_W-1:0]   green_lsb;
        logic [CUT_W-1:0]   blue_cut;
        logic [POS_W-1:0]   blue_lsb;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
        logic [7:0]         red_in;
        logic [7:0]         green_in;
        logic [7:0]         blue_in;
    } pix_t;

    // one packed pixel handed to the byte emitter
    typedef struct packed {
        logic                 load;
        logic [WORD_BITS-1:0] word;
        logic [OFFSET_W-1:0]  base;
        logic [BPP_W-1:0]     nbytes;
    } packed_t;

    function automatic logic [WORD_BITS-1:0] place_component(
        input logic [7:0]       comp,
        input logic [CUT_W-1:0] cut,
        input logic [POS_W-1:0] pos
    );
        logic [7:0] v;
        begin
            v = comp >> cut;
            place_component = {{(WORD_BITS-8){1'b0}}, v} << pos;
        end
    endfunction

endpackage

/* rtl/rgbpk_cfg_regs.sv */
// rgbpk_cfg_regs: configuration register file written over the cfg channel
// depends on rgbpk_pkg
module rgbpk_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [rgbpk_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [rgbpk_pkg::CFG_DATA_W-1:0]    wr_data,
    output rgbpk_pkg::cfg_t                     cfg
);

    rgbpk_pkg::cfg_t cfg_reg;
    rgbpk_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                rgbpk_pkg::REG_BYTES_PER_PIXEL:
                    cfg_next.bytes_per_pixel = wr_data[rgbpk_pkg::BPP_W-1:0];
                rgbpk_pkg::REG_LINE_PITCH:
                    cfg_next.line_pitch = wr_data[rgbpk_pkg::PITCH_W-1:0];
                rgbpk_pkg::REG_RED_CUT:
                    cfg_next.red_cut = wr_data[rgbpk_pkg::CUT_W-1:0];
                rgbpk_pkg::REG_RED_LSB:
                    cfg_next.red_lsb = wr_data[rgbpk_pkg::POS_W-1:0];
                rgbpk_pkg::REG_GREEN_CUT:
                    cfg_next.green_cut = wr_data[rgbpk_pkg::CUT_W-1:0];
                rgbpk_pkg::REG_GREEN_LSB:
                    cfg_next.green_lsb = wr_data[rgbpk_pkg::POS_W-1:0];
                rgbpk_pkg::REG_BLUE_CUT:
                    cfg_next.blue_cut = wr_data[rgbpk_pkg::CUT_W-1:0];
                rgbpk_pkg::REG_BLUE_LSB:
                    cfg_next.blue_lsb = wr_data[rgbpk_pkg::POS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bytes_per_pixel <= 3'd4;
            cfg_reg.line_pitch      <= 16'd4096;
            cfg_reg.red_cut         <= 4'd0;
            cfg_reg.red_lsb         <= 5'd16;
            cfg_reg.green_cut       <= 4'd0;
            cfg_reg.green_lsb       <= 5'd8;
            cfg_reg.blue_cut        <= 4'd0;
            cfg_reg.blue_lsb        <= 5'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/rgbpk_pack.sv */
// rgbpk_pack: input register and the packing logic (color word, base offset)
// depends on rgbpk_pkg
module rgbpk_pack #(
    parameter logic [15:0] MAX_WIDTH  = rgbpk_pkg::MAX_WIDTH,
    parameter logic [15:0] MAX_HEIGHT = rgbpk_pkg::MAX_HEIGHT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  rgbpk_pkg::pix_t     pix,
    input  rgbpk_pkg::cfg_t     cfg,
    input  logic                take,
    output logic                full,
    output rgbpk_pkg::packed_t  pk
);

    localparam int COL_OFF_W = rgbpk_pkg::COORD_W + rgbpk_pkg::BPP_W;

    logic                                  valid_reg;
    logic                                  valid_next;
    rgbpk_pkg::pix_t                       pix_reg;
    logic [rgbpk_pkg::BPP_W-1:0]           bpp_eff;
    logic                                  on_screen;
    logic [rgbpk_pkg::OFFSET_W-1:0]        row_off;
    logic [COL_OFF_W-1:0]                  col_off;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            pix_reg <= pix;
    end

    // byte counts above four behave as four
    assign bpp_eff = (cfg.bytes_per_pixel > rgbpk_pkg::BPP_W'(rgbpk_pkg::MAX_BPP))
                   ? rgbpk_pkg::BPP_W'(rgbpk_pkg::MAX_BPP) : cfg.bytes_per_pixel;

    assign on_screen = ({4'd0, pix_reg.pixel_column} < MAX_WIDTH)
                    && ({4'd0, pix_reg.pixel_row} < MAX_HEIGHT);

    assign row_off = rgbpk_pkg::OFFSET_W'(pix_reg.pixel_row)
                   * rgbpk_pkg::OFFSET_W'(cfg.line_pitch);
    assign col_off = COL_OFF_W'(pix_reg.pixel_column) * COL_OFF_W'(bpp_eff);

    always_comb
    begin
        pk.load   = valid_reg && on_screen && (bpp_eff != '0);
        pk.word   = rgbpk_pkg::place_component(pix_reg.red_in, cfg.red_cut, cfg.red_lsb)
                  | rgbpk_pkg::place_component(pix_reg.green_in, cfg.green_cut,
                                               cfg.green_lsb)
                  | rgbpk_pkg::place_component(pix_reg.blue_in, cfg.blue_cut,
                                               cfg.blue_lsb);
        pk.base   = row_off + rgbpk_pkg::OFFSET_W'(col_off);
        pk.nbytes = bpp_eff;
    end

    assign full = valid_reg;

endmodule

/* rtl/rgbpk_emit.sv */
// rgbpk_emit: result register that sends one packed word out a byte per cycle
// depends on rgbpk_pkg
module rgbpk_emit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rgbpk_pkg::packed_t                  pk,
    input  logic                                pk_valid,
    output logic                                take,
    output logic                                strobe,
    output logic [rgbpk_pkg::OFFSET_W-1:0]      byte_offset,
    output logic [7:0]                          byte_value,
    output logic                                last_byte
);

    logic                                  valid_reg;
    logic                                  valid_next;
    logic [rgbpk_pkg::WORD_BITS-1:0]       word_reg;
    logic [rgbpk_pkg::WORD_BITS-1:0]       word_next;
    logic [rgbpk_pkg::OFFSET_W-1:0]        off_reg;
    logic [rgbpk_pkg::OFFSET_W-1:0]        off_next;
    logic [rgbpk_pkg::BPP_W-1:0]           rem_reg;
    logic [rgbpk_pkg::BPP_W-1:0]           rem_next;
    logic                                  last;
    logic                                  load;

    assign last = valid_reg && (rem_reg == rgbpk_pkg::BPP_W'(1));
    // free for a new word once the current one shows its final byte
    assign take = !valid_reg || last;
    assign load = take && pk_valid && pk.load;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        off_next   = off_reg;
        rem_next   = rem_reg;
        if (load)
        begin
            valid_next = 1'b1;
            word_next  = pk.word;
            off_next   = pk.base;
            rem_next   = pk.nbytes;
        end
        else if (last)
        begin
            valid_next = 1'b0;
        end
        else if (valid_reg)
        begin
            word_next = word_reg >> rgbpk_pkg::BYTE_BITS;
            off_next  = off_reg + rgbpk_pkg::OFFSET_W'(1);
            rem_next  = rem_reg - rgbpk_pkg::BPP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rem_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        off_reg  <= off_next;
    end

    assign strobe      = valid_reg;
    assign byte_offset = off_reg;
    assign byte_value  = word_reg[7:0];
    assign last_byte   = last;

endmodule

/* rtl/rgb888_direct_color_pixel_packer_core.sv */
// rgb888_direct_color_pixel_packer_core: top level of the pixel packer
// depends on rgbpk_pkg, rgbpk_cfg_regs, rgbpk_pack, rgbpk_emit
//
// channel   direction  handshake               word
// pixel     in         start, busy             pixel_column, pixel_row, red/green/blue_in
// config    in         cfg_valid, cfg_ready    cfg_index, cfg_data
// bytes     out        strobe (no back-press)  byte_offset, byte_value, last_byte
//
// a pixel goes input register -> packing logic -> byte emitter; the emitter loads the
// packed word from the input register once it is free, and the word then holds the
// emitter until all bytes_per_pixel bytes (one to four) are sent.
// busy rises while a pixel waits in the input register behind a word still
// being sent; off-screen pixels and zero bytes per pixel give no bytes.
// reset clears both stages and loads the register defaults; cfg_ready is
// always high.
module rgb888_direct_color_pixel_packer_core #(
    parameter logic [15:0] MAX_WIDTH  = rgbpk_pkg::MAX_WIDTH,
    parameter logic [15:0] MAX_HEIGHT = rgbpk_pkg::MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rgbpk_pkg::COORD_W-1:0]       pixel_column,
    input  logic [rgbpk_pkg::COORD_W-1:0]       pixel_row,
    input  logic [7:0]                          red_in,
    input  logic [7:0]                          green_in,
    input  logic [7:0]                          blue_in,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rgbpk_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgbpk_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                strobe,
    output logic [rgbpk_pkg::OFFSET_W-1:0]      byte_offset,
    output logic [7:0]                          byte_value,
    output logic                                last_byte
);

    rgbpk_pkg::cfg_t    cfg;
    rgbpk_pkg::pix_t    pix;
    rgbpk_pkg::packed_t pk;
    logic               full;
    logic               take;
    logic               accept;

    assign cfg_ready = 1'b1;
    assign busy      = full && !take;
    assign accept    = start && !busy;

    assign pix.pixel_column = pixel_column;
    assign pix.pixel_row    = pixel_row;
    assign pix.red_in       = red_in;
    assign pix.green_in     = green_in;
    assign pix.blue_in      = blue_in;

    rgbpk_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rgbpk_pack #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_pack (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pix    (pix),
        .cfg    (cfg),
        .take   (take),
        .full   (full),
        .pk     (pk)
    );

    rgbpk_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .pk          (pk),
        .pk_valid    (full),
        .take        (take),
        .strobe      (strobe),
        .byte_offset (byte_offset),
        .byte_value  (byte_value),
        .last_byte   (last_byte)
    );

endmodule

/* rtl/rgbpk_checker.sv */
// rgbpk_checker: port-level assertions for the pixel packer, bound to the top
// depends on rgbpk_pkg and rgb888_direct_color_pixel_packer_core
module rgbpk_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                busy,
    input  logic                                strobe,
    input  logic [rgbpk_pkg::OFFSET_W-1:0]      byte_offset,
    input  logic                                last_byte
);

    // last mark only on a real byte
    a_last_has_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |-> strobe)
        else $error("last_byte without strobe");

    // bytes of one word come in consecutive cycles
    a_word_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_byte) |=> strobe)
        else $error("gap inside a word");

    // offsets within a word step by one
    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last_byte) |=> (byte_offset == $past(byte_offset) + 28'd1))
        else $error("byte_offset did not step by one");

    // busy only while a word is mid-flight
    a_busy_mid_word: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (strobe && !last_byte))
        else $error("busy without a word in progress");

endmodule

bind rgb888_direct_color_pixel_packer_core rgbpk_checker u_rgbpk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .busy        (busy),
    .strobe      (strobe),
    .byte_offset (byte_offset),
    .last_byte   (last_byte)
);

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives rgb888_direct_color_pixel_packer_core with directed and random pixels
// under several register settings, predicting every byte write and checking it in order
// depends on rgbpk_pkg and the core rtl

module testbench;

    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 2000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 30;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [rgbpk_pkg::OFFSET_W-1:0] offset;
        logic [7:0]                     value;
        logic                           last;
    } fb_write_t;

    logic                             clk;
    logic                             rst_n;
    logic                             start;
    logic                             busy;
    logic [rgbpk_pkg::COORD_W-1:0]    pixel_column;
    logic [rgbpk_pkg::COORD_W-1:0]    pixel_row;
    logic [7:0]                       red_in;
    logic [7:0]                       green_in;
    logic [7:0]                       blue_in;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rgbpk_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rgbpk_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                             strobe;
    logic [rgbpk_pkg::OFFSET_W-1:0]   byte_offset;
    logic [7:0]                       byte_value;
    logic                             last_byte;

    rgbpk_pkg::cfg_t shadow_cfg;
    fb_write_t       pending_writes[$];
    int              mismatches;
    int              pixels_sent;
    int              writes_checked;
    int              settings_applied;

    rgb888_direct_color_pixel_packer_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_column (pixel_column),
        .pixel_row    (pixel_row),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .strobe       (strobe),
        .byte_offset  (byte_offset),
        .byte_value   (byte_value),
        .last_byte    (last_byte)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic rgbpk_pkg::cfg_t default_cfg();
        rgbpk_pkg::cfg_t c;
        c.bytes_per_pixel = 3'd4;
        c.line_pitch      = 16'd4096;
        c.red_cut         = 4'd0;
        c.red_lsb         = 5'd16;
        c.green_cut       = 4'd0;
        c.green_lsb       = 5'd8;
        c.blue_cut        = 4'd0;
        c.blue_lsb        = 5'd0;
        return c;
    endfunction

    function automatic logic [rgbpk_pkg::WORD_BITS-1:0] color_field(
        input logic [7:0]                  comp,
        input logic [rgbpk_pkg::CUT_W-1:0] cut,
        input logic [rgbpk_pkg::POS_W-1:0] pos
    );
        logic [rgbpk_pkg::WORD_BITS-1:0] wide;
        wide = {{(rgbpk_pkg::WORD_BITS-8){1'b0}}, comp};
        wide = wide >> cut;
        // bits pushed past the top of the word are simply lost
        return wide << pos;
    endfunction

    // builds the byte writes that one accepted pixel should produce
    function automatic void predict_writes(input rgbpk_pkg::pix_t px);
        logic [rgbpk_pkg::WORD_BITS-1:0] color;
        logic [31:0]                     base;
        int                              nbytes;
        fb_write_t                       w;
        if (px.pixel_column >= rgbpk_pkg::MAX_WIDTH || px.pixel_row >= rgbpk_pkg::MAX_HEIGHT)
            return;
        nbytes = (shadow_cfg.bytes_per_pixel > rgbpk_pkg::MAX_BPP)
               ? rgbpk_pkg::MAX_BPP : int'(shadow_cfg.bytes_per_pixel);
        if (nbytes == 0)
            return;
        color = color_field(px.red_in, shadow_cfg.red_cut, shadow_cfg.red_lsb)
              | color_field(px.green_in, shadow_cfg.green_cut, shadow_cfg.green_lsb)
              | color_field(px.blue_in, shadow_cfg.blue_cut, shadow_cfg.blue_lsb);
        base = 32'(px.pixel_row) * 32'(shadow_cfg.line_pitch)
             + 32'(px.pixel_column) * 32'(nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            w.offset = rgbpk_pkg::OFFSET_W'(base + 32'(i));
            w.value  = color[8*i +: 8];
            w.last   = (i == nbytes - 1);
            pending_writes.push_back(w);
        end
    endfunction

    function automatic rgbpk_pkg::pix_t random_pixel();
        rgbpk_pkg::pix_t px;
        px.pixel_column = rgbpk_pkg::COORD_W'($urandom_range(0, 4095));
        px.pixel_row    = rgbpk_pkg::COORD_W'($urandom_range(0, 4095));
        px.red_in       = 8'($urandom_range(0, 255));
        px.green_in     = 8'($urandom_range(0, 255));
        px.blue_in      = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            px.pixel_column = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        if ($urandom_range(0, 7) == 0)
            px.pixel_row = $urandom_range(0, 1) ? 12'hfff : 12'h000;
        return px;
    endfunction

    // every byte write is compared against the oldest prediction
    always @(posedge clk)
    begin : check_writes
        fb_write_t want;
        if (rst_n && strobe)
        begin
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected byte write: offset %0d value %02h last %0b",
                             byte_offset, byte_value, last_byte);
            end
            else
            begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (byte_offset !== want.offset || byte_value !== want.value
                    || last_byte !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("byte write mismatch: expected offset %0d value %02h last %0b",
                                 want.offset, want.value, want.last);
                        $display("                     got offset %0d value %02h last %0b",
                                 byte_offset, byte_value, last_byte);
                    end
                end
            end
        end
    end

    // drives one pixel and returns at the edge where it is taken
    task automatic send_pixel(input rgbpk_pkg::pix_t px);
        start        <= 1'b1;
        pixel_column <= px.pixel_column;
        pixel_row    <= px.pixel_row;
        red_in       <= px.red_in;
        green_in     <= px.green_in;
        blue_in      <= px.blue_in;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_writes(px);
        pixels_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic drain_writes();
        int waited;
        waited = 0;
        start <= 1'b0;
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // off-screen or zero-width pixels may still be in flight with nothing predicted
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [rgbpk_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rgbpk_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            rgbpk_pkg::REG_BYTES_PER_PIXEL:
                shadow_cfg.bytes_per_pixel = data[rgbpk_pkg::BPP_W-1:0];
            rgbpk_pkg::REG_LINE_PITCH:
                shadow_cfg.line_pitch = data[rgbpk_pkg::PITCH_W-1:0];
            rgbpk_pkg::REG_RED_CUT:
                shadow_cfg.red_cut = data[rgbpk_pkg::CUT_W-1:0];
            rgbpk_pkg::REG_RED_LSB:
                shadow_cfg.red_lsb = data[rgbpk_pkg::POS_W-1:0];
            rgbpk_pkg::REG_GREEN_CUT:
                shadow_cfg.green_cut = data[rgbpk_pkg::CUT_W-1:0];
            rgbpk_pkg::REG_GREEN_LSB:
                shadow_cfg.green_lsb = data[rgbpk_pkg::POS_W-1:0];
            rgbpk_pkg::REG_BLUE_CUT:
                shadow_cfg.blue_cut = data[rgbpk_pkg::CUT_W-1:0];
            rgbpk_pkg::REG_BLUE_LSB:
                shadow_cfg.blue_lsb = data[rgbpk_pkg::POS_W-1:0];
            default: ;
        endcase
    endtask

    // unused upper data bits carry noise, the block must ignore them
    task automatic apply_config(input rgbpk_pkg::cfg_t c);
        logic [rgbpk_pkg::CFG_DATA_W-1:0] data;
        drain_writes();
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::BPP_W-1:0] = c.bytes_per_pixel;
        write_reg(rgbpk_pkg::REG_BYTES_PER_PIXEL, data);
        write_reg(rgbpk_pkg::REG_LINE_PITCH, c.line_pitch);
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::CUT_W-1:0] = c.red_cut;
        write_reg(rgbpk_pkg::REG_RED_CUT, data);
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::POS_W-1:0] = c.red_lsb;
        write_reg(rgbpk_pkg::REG_RED_LSB, data);
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::CUT_W-1:0] = c.green_cut;
        write_reg(rgbpk_pkg::REG_GREEN_CUT, data);
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::POS_W-1:0] = c.green_lsb;
        write_reg(rgbpk_pkg::REG_GREEN_LSB, data);
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::CUT_W-1:0] = c.blue_cut;
        write_reg(rgbpk_pkg::REG_BLUE_CUT, data);
        data = rgbpk_pkg::CFG_DATA_W'($urandom);
        data[rgbpk_pkg::POS_W-1:0] = c.blue_lsb;
        write_reg(rgbpk_pkg::REG_BLUE_LSB, data);
        cfg_valid <= 1'b0;
        settings_applied++;
    endtask

    task automatic test_reset_defaults();
        send_pixel({12'd0, 12'd0, 8'h00, 8'h00, 8'h00});
        send_pixel({12'd4095, 12'd4095, 8'hff, 8'hff, 8'hff});
        send_pixel({12'd4095, 12'd0, 8'hff, 8'h00, 8'haa});
        send_pixel({12'd0, 12'd4095, 8'h55, 8'haa, 8'h0f});
        send_pixel({12'd1234, 12'd2345, 8'h12, 8'h34, 8'h56});
        drain_writes();
    endtask

    // zero writes nothing, five to seven behave as four
    task automatic test_byte_widths();
        rgbpk_pkg::cfg_t c;
        c = default_cfg();
        for (int bpp = 0; bpp < 8; bpp++)
        begin
            c.bytes_per_pixel = rgbpk_pkg::BPP_W'(bpp);
            apply_config(c);
            send_pixel({12'd4095, 12'd7, 8'hc3, 8'h5a, 8'h81});
        end
        drain_writes();
    endtask

    task automatic test_field_extremes();
        rgbpk_pkg::cfg_t c;
        for (int k = 0; k < 3; k++)
        begin
            c = default_cfg();
            case (k)
                0:
                begin
                    // cuts wipe out red and green, blue lsb lands on bit 31
                    c.line_pitch = 16'hffff;
                    c.red_cut    = 4'd15;
                    c.red_lsb    = 5'd31;
                    c.green_cut  = 4'd8;
                    c.green_lsb  = 5'd31;
                    c.blue_lsb   = 5'd31;
                end
                1:
                begin
                    // fields run off the top of the word
                    c.bytes_per_pixel = 3'd3;
                    c.line_pitch      = 16'd1;
                    c.red_lsb         = 5'd24;
                    c.green_lsb       = 5'd28;
                    c.blue_lsb        = 5'd31;
                end
                default:
                begin
                    // overlapping fields at bit 0, zero pitch
                    c.bytes_per_pixel = 3'd2;
                    c.line_pitch      = 16'd0;
                    c.red_cut         = 4'd7;
                    c.red_lsb         = 5'd0;
                    c.green_cut       = 4'd1;
                    c.green_lsb       = 5'd0;
                    c.blue_cut        = 4'd4;
                end
            endcase
            apply_config(c);
            send_pixel({12'd4095, 12'd4095, 8'hff, 8'hff, 8'hff});
            send_pixel({12'd0, 12'd0, 8'h80, 8'h01, 8'hff});
            send_pixel({12'd1, 12'd4094, 8'ha5, 8'h5a, 8'hc3});
        end
        drain_writes();
    endtask

    task automatic test_random_traffic();
        rgbpk_pkg::cfg_t c;
        int              burst_left;
        bit              gapless;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            c.bytes_per_pixel = rgbpk_pkg::BPP_W'($urandom_range(1, 7));
            case ($urandom_range(0, 3))
                0:       c.line_pitch = rgbpk_pkg::PITCH_W'($urandom_range(0, 16));
                1:       c.line_pitch = rgbpk_pkg::PITCH_W'($urandom_range(65000, 65535));
                default: c.line_pitch = rgbpk_pkg::PITCH_W'($urandom);
            endcase
            if (phase == 0)
                c.line_pitch = 16'hffff;
            c.red_cut   = rgbpk_pkg::CUT_W'(($urandom_range(0, 9) == 0)
                                            ? $urandom_range(9, 15) : $urandom_range(0, 8));
            c.green_cut = rgbpk_pkg::CUT_W'(($urandom_range(0, 9) == 0)
                                            ? $urandom_range(9, 15) : $urandom_range(0, 8));
            c.blue_cut  = rgbpk_pkg::CUT_W'(($urandom_range(0, 9) == 0)
                                            ? $urandom_range(9, 15) : $urandom_range(0, 8));
            c.red_lsb   = rgbpk_pkg::POS_W'($urandom_range(0, 31));
            c.green_lsb = rgbpk_pkg::POS_W'($urandom_range(0, 31));
            c.blue_lsb  = rgbpk_pkg::POS_W'($urandom_range(0, 31));
            apply_config(c);
            gapless    = (phase % 3 == 0);
            burst_left = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 12);
                    if (!gapless)
                        pause_sender($urandom_range(1, 6));
                end
                send_pixel(random_pixel());
                burst_left--;
            end
        end
        drain_writes();
    endtask

    initial
    begin
        rst_n            = 1'b0;
        start            = 1'b0;
        pixel_column     = '0;
        pixel_row        = '0;
        red_in           = '0;
        green_in         = '0;
        blue_in          = '0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        mismatches       = 0;
        pixels_sent      = 0;
        writes_checked   = 0;
        settings_applied = 0;
        shadow_cfg       = default_cfg();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_byte_widths();
        test_field_extremes();
        test_random_traffic();

        if (pending_writes.size() != 0)
        begin
            $display("%0d predicted byte writes never arrived", pending_writes.size());
            mismatches += pending_writes.size();
        end
        $display("sent %0d pixels under %0d register settings, checked %0d byte writes",
                 pixels_sent, settings_applied, writes_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("timeout with %0d byte writes outstanding", pending_writes.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
